### hdl/ppgcq_pkg.sv
package ppgcq_pkg;

    localparam int WINDOW_LEN_DEF = 32;

    localparam int SAMPLE_W = 18;
    localparam int SUM_W    = 26;
    localparam int SQ_W     = 44;
    localparam int CNT_W    = 8;
    localparam int MULT_W   = 10;
    localparam int THR_W    = 16;
    localparam int WIN_W    = 9;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int BM_W     = SAMPLE_W + MULT_W;
    localparam int WEAK_W   = BM_W + WIN_W;
    localparam int S2_W     = 2 * SUM_W;
    localparam int HALF_Q_W = SQ_W / 2;
    localparam int NQP_W    = HALF_Q_W + WIN_W;
    localparam int NQ_W     = SQ_W + WIN_W;
    localparam int T2_W     = 2 * THR_W;
    localparam int HALF_S2_W = S2_W / 2;
    localparam int TSP_W    = T2_W + HALF_S2_W;
    localparam int RHS_W    = T2_W + S2_W;
    localparam int SPN_W    = SAMPLE_W + WIN_W;
    localparam int RIP_W    = SPN_W + THR_W;
    localparam int RPROD_W  = THR_W + SUM_W;

    localparam logic [SAMPLE_W-1:0] BASELINE_RST = 18'd1;
    localparam logic [MULT_W-1:0]   MULT_RST     = 10'd307;
    localparam logic [THR_W-1:0]    STAB_RST     = 16'd9830;
    localparam logic [THR_W-1:0]    RMIN_RST     = 16'd131;
    localparam logic [THR_W-1:0]    RMAX_RST     = 16'd9830;

    typedef enum logic [2:0] {
        REG_BASELINE = 3'd0,
        REG_MULT     = 3'd1,
        REG_STAB     = 3'd2,
        REG_RMIN     = 3'd3,
        REG_RMAX     = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        VERDICT_GOOD        = 3'd0,
        VERDICT_WEAK        = 3'd1,
        VERDICT_UNSTABLE    = 3'd2,
        VERDICT_RIPPLE_LOW  = 3'd3,
        VERDICT_RIPPLE_HIGH = 3'd4
    } verdict_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_BL, OP_BLN, OP_SS, OP_NQL, OP_NQH, OP_TT, OP_TSL,
        OP_TSH, OP_SPN, OP_RMIN, OP_RMAX, OP_NQ, OP_DEV, OP_RHS, OP_DEC
    } op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] baseline;
        logic [MULT_W-1:0]   mult;
        logic [THR_W-1:0]    stab;
        logic [THR_W-1:0]    rmin;
        logic [THR_W-1:0]    rmax;
    } cfg_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

### hdl/ppg_contact_quality_check.sv
// Samples are taken one per cycle while a window fills.
// After the edge that takes the last sample of a window, the 15-step sequence around the
// shared multiplier runs, then the wait state; the result is loaded in the emit state once
// the output is free, and it and the first sample of the next window can both go at the
// following edge. A result still waiting holds the input until it is taken.
// Synchronous active-low reset clears the accumulators and loads register defaults.
module ppg_contact_quality_check
    import ppgcq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [17:0] ir_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] verdict, [3] finger_ok, [21:4] mean_level, [39:22] min_level,
    // [57:40] max_level
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                cfg_reg;
    cmd_t                cmd;
    stat_t               stat;
    logic                cfg_wr;
    verdict_t            verdict;
    logic                finger_ok;
    logic [SAMPLE_W-1:0] mean_level;
    logic [SAMPLE_W-1:0] min_level;
    logic [SAMPLE_W-1:0] max_level;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline <= BASELINE_RST;
            cfg_reg.mult     <= MULT_RST;
            cfg_reg.stab     <= STAB_RST;
            cfg_reg.rmin     <= RMIN_RST;
            cfg_reg.rmax     <= RMAX_RST;
        end else if (cfg_wr) begin
            case (paddr[APB_ADDR_W-1:2])
                REG_BASELINE: cfg_reg.baseline <= pwdata[SAMPLE_W-1:0];
                REG_MULT:     cfg_reg.mult     <= pwdata[MULT_W-1:0];
                REG_STAB:     cfg_reg.stab     <= pwdata[THR_W-1:0];
                REG_RMIN:     cfg_reg.rmin     <= pwdata[THR_W-1:0];
                REG_RMAX:     cfg_reg.rmax     <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_ADDR_W-1:2])
            REG_BASELINE: prdata = APB_DATA_W'(cfg_reg.baseline);
            REG_MULT:     prdata = APB_DATA_W'(cfg_reg.mult);
            REG_STAB:     prdata = APB_DATA_W'(cfg_reg.stab);
            REG_RMIN:     prdata = APB_DATA_W'(cfg_reg.rmin);
            REG_RMAX:     prdata = APB_DATA_W'(cfg_reg.rmax);
            default:      prdata = '0;
        endcase
    end

    ppgcq_ctrl #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppgcq_dp #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .verdict   (verdict),
        .finger_ok (finger_ok),
        .mean_level(mean_level),
        .min_level (min_level),
        .max_level (max_level)
    );

    assign m_tdata = {6'b0, max_level, min_level, mean_level, finger_ok, verdict};

    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_busy |-> !s_tready)
        else $error("request accepted while mean divider busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (finger_ok == (verdict == VERDICT_GOOD)))
        else $error("finger_ok disagrees with verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (min_level <= mean_level) && (mean_level <= max_level))
        else $error("mean outside window extremes");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !cmd.acc_en)
        else $error("window cleared while a request is taken");

endmodule

### hdl/ppgcq_div.sv
module ppgcq_div
    import ppgcq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    output logic [SAMPLE_W-1:0] quotient,
    output logic                busy
);

    localparam int REM_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SHIFT   = SUM_W + REM_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] q_reg;

    // multiply by the rounded-up reciprocal of the window length
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    assign busy     = start;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (start) begin
            q_reg <= prod[SHIFT +: SAMPLE_W];
        end
    end

endmodule

### hdl/ppgcq_dp.sv
module ppgcq_dp
    import ppgcq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                m_tready,
    output logic                m_tvalid,
    output verdict_t            verdict,
    output logic                finger_ok,
    output logic [SAMPLE_W-1:0] mean_level,
    output logic [SAMPLE_W-1:0] min_level,
    output logic [SAMPLE_W-1:0] max_level
);

    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [SAMPLE_W-1:0]   min_reg;
    logic [SAMPLE_W-1:0]   max_reg;
    logic [2*SAMPLE_W-1:0] sample_sq;

    logic [BM_W-1:0]    bm_reg;
    logic [WEAK_W-1:0]  weak_rhs_reg;
    logic [S2_W-1:0]    s2_reg;
    logic [NQP_W-1:0]   nql_reg;
    logic [NQP_W-1:0]   nqh_reg;
    logic [T2_W-1:0]    t2_reg;
    logic [TSP_W-1:0]   tsl_reg;
    logic [TSP_W-1:0]   tsh_reg;
    logic [SPN_W-1:0]   spn_reg;
    logic [RPROD_W-1:0] rmin_prod_reg;
    logic [RPROD_W-1:0] rmax_prod_reg;
    logic [NQ_W-1:0]    nq_reg;
    logic [NQ_W-1:0]    dev_reg;
    logic [RHS_W-1:0]   rhs_reg;
    verdict_t           verdict_reg;

    logic                out_valid_reg;
    verdict_t            verdict_out_reg;
    logic                ok_out_reg;
    logic [SAMPLE_W-1:0] mean_out_reg;
    logic [SAMPLE_W-1:0] min_out_reg;
    logic [SAMPLE_W-1:0] max_out_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [SUM_W-1:0]   mul_s;
    logic [MUL_B_W-1:0] win_b;
    logic [SAMPLE_W-1:0] spread;

    logic [WEAK_W-1:0]  weak_lhs;
    logic [RHS_W:0]     unst_lhs;
    logic [RIP_W-1:0]   rip_lhs;
    logic [NQ_W-1:0]    s2_ext;
    logic [NQ_W-1:0]    nq_sum;
    logic [RHS_W-1:0]   rhs_sum;

    logic                div_busy;
    logic [SAMPLE_W-1:0] quotient;

    ppgcq_div #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(sum_reg),
        .quotient(quotient),
        .busy    (div_busy)
    );

    assign sample_sq = sample * sample;
    assign mul_s     = (sum_reg == '0) ? SUM_W'(1) : sum_reg;
    assign win_b     = (sum_reg == '0) ? MUL_B_W'(1) : MUL_B_W'(WINDOW_LEN);
    assign spread    = (max_reg >= min_reg) ? max_reg - min_reg : '0;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_BL: begin
                mul_a = MUL_A_W'(cfg.baseline);
                mul_b = MUL_B_W'(cfg.mult);
            end
            OP_BLN: begin
                mul_a = MUL_A_W'(bm_reg);
                mul_b = MUL_B_W'(WINDOW_LEN);
            end
            OP_SS: begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(sum_reg);
            end
            OP_NQL: begin
                mul_a = MUL_A_W'(sq_reg[HALF_Q_W-1:0]);
                mul_b = MUL_B_W'(WINDOW_LEN);
            end
            OP_NQH: begin
                mul_a = MUL_A_W'(sq_reg[SQ_W-1:HALF_Q_W]);
                mul_b = MUL_B_W'(WINDOW_LEN);
            end
            OP_TT: begin
                mul_a = MUL_A_W'(cfg.stab);
                mul_b = MUL_B_W'(cfg.stab);
            end
            OP_TSL: begin
                mul_a = MUL_A_W'(t2_reg);
                mul_b = MUL_B_W'(s2_reg[HALF_S2_W-1:0]);
            end
            OP_TSH: begin
                mul_a = MUL_A_W'(t2_reg);
                mul_b = MUL_B_W'(s2_reg[S2_W-1:HALF_S2_W]);
            end
            OP_SPN: begin
                mul_a = MUL_A_W'(spread);
                mul_b = win_b;
            end
            OP_RMIN: begin
                mul_a = MUL_A_W'(cfg.rmin);
                mul_b = MUL_B_W'(mul_s);
            end
            OP_RMAX: begin
                mul_a = MUL_A_W'(cfg.rmax);
                mul_b = MUL_B_W'(mul_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign s2_ext   = NQ_W'(s2_reg);
    assign nq_sum   = (NQ_W'(nqh_reg) << HALF_Q_W) + NQ_W'(nql_reg);
    assign rhs_sum  = (RHS_W'(tsh_reg) << HALF_S2_W) + RHS_W'(tsl_reg);
    assign weak_lhs = WEAK_W'({sum_reg, 8'b0});
    assign unst_lhs = {dev_reg, 32'b0};
    assign rip_lhs  = {spn_reg, 16'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end else if (cmd.load_out) begin
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end else if (cmd.acc_en) begin
            sum_reg <= sum_reg + SUM_W'(sample);
            sq_reg  <= sq_reg + SQ_W'(sample_sq);
            if (sample < min_reg) begin
                min_reg <= sample;
            end
            if (sample > max_reg) begin
                max_reg <= sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_BL:   bm_reg        <= mul_p[BM_W-1:0];
            OP_BLN:  weak_rhs_reg  <= mul_p[WEAK_W-1:0];
            OP_SS:   s2_reg        <= mul_p[S2_W-1:0];
            OP_NQL:  nql_reg       <= mul_p[NQP_W-1:0];
            OP_NQH:  nqh_reg       <= mul_p[NQP_W-1:0];
            OP_TT:   t2_reg        <= mul_p[T2_W-1:0];
            OP_TSL:  tsl_reg       <= mul_p[TSP_W-1:0];
            OP_TSH:  tsh_reg       <= mul_p[TSP_W-1:0];
            OP_SPN:  spn_reg       <= mul_p[SPN_W-1:0];
            OP_RMIN: rmin_prod_reg <= mul_p[RPROD_W-1:0];
            OP_RMAX: rmax_prod_reg <= mul_p[RPROD_W-1:0];
            OP_NQ:   nq_reg        <= nq_sum;
            OP_DEV:  dev_reg       <= (nq_reg > s2_ext) ? nq_reg - s2_ext : '0;
            OP_RHS:  rhs_reg       <= rhs_sum;
            OP_DEC: begin
                if (weak_lhs < weak_rhs_reg) begin
                    verdict_reg <= VERDICT_WEAK;
                end else if (unst_lhs > {1'b0, rhs_reg}) begin
                    verdict_reg <= VERDICT_UNSTABLE;
                end else if (rip_lhs < RIP_W'(rmin_prod_reg)) begin
                    verdict_reg <= VERDICT_RIPPLE_LOW;
                end else if (rip_lhs > RIP_W'(rmax_prod_reg)) begin
                    verdict_reg <= VERDICT_RIPPLE_HIGH;
                end else begin
                    verdict_reg <= VERDICT_GOOD;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            verdict_out_reg <= verdict_reg;
            ok_out_reg      <= (verdict_reg == VERDICT_GOOD);
            mean_out_reg    <= quotient;
            min_out_reg     <= min_reg;
            max_out_reg     <= max_reg;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign verdict    = verdict_out_reg;
    assign finger_ok  = ok_out_reg;
    assign mean_level = mean_out_reg;
    assign min_level  = min_out_reg;
    assign max_level  = max_out_reg;

endmodule

### hdl/ppgcq_ctrl.sv
module ppgcq_ctrl
    import ppgcq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WINDOW_LEN - 1);

    typedef enum logic [1:0] {
        ST_ACC,
        ST_CALC,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    op_t              op_reg;
    logic             start_reg;
    logic             acc;

    assign s_tready = (state_reg == ST_ACC);
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            op_reg    <= OP_NONE;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_ACC: begin
                    if (acc) begin
                        if (cnt_reg == LAST_IDX) begin
                            cnt_reg   <= '0;
                            op_reg    <= OP_BL;
                            start_reg <= 1'b1;
                            state_reg <= ST_CALC;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                ST_CALC: begin
                    if (op_reg == OP_DEC) begin
                        op_reg    <= OP_NONE;
                        state_reg <= ST_WAIT;
                    end else begin
                        op_reg <= op_t'(op_reg + 4'd1);
                    end
                end
                ST_WAIT: begin
                    if (!stat.div_busy) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (stat.out_free) begin
                        state_reg <= ST_ACC;
                    end
                end
                default: begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

    assign cmd.acc_en    = acc;
    assign cmd.div_start = start_reg;
    assign cmd.op        = op_reg;
    assign cmd.load_out  = (state_reg == ST_EMIT) && stat.out_free;

endmodule

### sim/ppgcq_verdict_monitor.sv
module ppgcq_verdict_monitor
    import ppgcq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [17:0] ir_sample
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] verdict, [3] finger_ok, [21:4] mean_level, [39:22] min_level,
    // [57:40] max_level
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    verdicts_due,
    output int                    error_count
);

    typedef struct packed {
        verdict_t            verdict;
        logic                finger_ok;
        logic [SAMPLE_W-1:0] mean_level;
        logic [SAMPLE_W-1:0] lo_level;
        logic [SAMPLE_W-1:0] hi_level;
    } window_report_t;

    cfg_t                cfg;
    logic [SUM_W-1:0]    level_acc;
    logic [SQ_W-1:0]     square_acc;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
    logic [CNT_W-1:0]    taken;
    window_report_t      pending_reports[$];
    int                  errs = 0;

    function automatic verdict_t grade_window(input logic [63:0] s, input logic [63:0] q,
                                              input logic [63:0] mn, input logic [63:0] mx);
        logic [63:0]  n, base, mult, stab, rmin, rmax;
        logic [63:0]  s2, nq, dev, spread, lhs, scale;
        logic [127:0] dev_w, bound;
        n    = 64'(WINDOW_LEN);
        base = 64'(cfg.baseline);
        mult = 64'(cfg.mult);
        stab = 64'(cfg.stab);
        rmin = 64'(cfg.rmin);
        rmax = 64'(cfg.rmax);
        if ((s << 8) < base * mult * n) return VERDICT_WEAK;
        s2    = s * s;
        nq    = n * q;
        dev   = (nq > s2) ? nq - s2 : 64'd0;
        dev_w = {64'd0, dev} << 32;
        bound = {64'd0, stab * stab} * {64'd0, s2};
        if (dev_w > bound) return VERDICT_UNSTABLE;
        spread = (mx >= mn) ? mx - mn : 64'd0;
        if (s == 64'd0) begin
            lhs   = spread << 16;
            scale = 64'd1;
        end else begin
            lhs   = (spread * n) << 16;
            scale = s;
        end
        if (lhs < rmin * scale) return VERDICT_RIPPLE_LOW;
        if (lhs > rmax * scale) return VERDICT_RIPPLE_HIGH;
        return VERDICT_GOOD;
    endfunction

    task automatic clear_window();
        level_acc  = '0;
        square_acc = '0;
        lowest     = '1;
        highest    = '0;
        taken      = '0;
    endtask

    task automatic take_sample(input logic [SAMPLE_W-1:0] x);
        logic [SQ_W-1:0] xx;
        window_report_t  rep;
        xx         = SQ_W'(x);
        level_acc  = level_acc + SUM_W'(x);
        square_acc = square_acc + xx * xx;
        if (x < lowest) lowest = x;
        if (x > highest) highest = x;
        if (int'(taken) + 1 < WINDOW_LEN) begin
            taken = taken + CNT_W'(1);
        end else begin
            rep.verdict    = grade_window(64'(level_acc), 64'(square_acc),
                                          64'(lowest), 64'(highest));
            rep.finger_ok  = (rep.verdict == VERDICT_GOOD);
            rep.mean_level = SAMPLE_W'(level_acc / SUM_W'(WINDOW_LEN));
            rep.lo_level   = lowest;
            rep.hi_level   = highest;
            pending_reports.push_back(rep);
            clear_window();
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errs++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        window_report_t want;
        if (!aresetn) begin
            cfg.baseline = BASELINE_RST;
            cfg.mult     = MULT_RST;
            cfg.stab     = STAB_RST;
            cfg.rmin     = RMIN_RST;
            cfg.rmax     = RMAX_RST;
            clear_window();
            pending_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_BASELINE: cfg.baseline = pwdata[SAMPLE_W-1:0];
                    REG_MULT:     cfg.mult     = pwdata[MULT_W-1:0];
                    REG_STAB:     cfg.stab     = pwdata[THR_W-1:0];
                    REG_RMIN:     cfg.rmin     = pwdata[THR_W-1:0];
                    REG_RMAX:     cfg.rmax     = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result, got %h", $time, m_tdata);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(m_tdata[2:0]));
                    check_field("finger_ok", 32'(want.finger_ok), 32'(m_tdata[3]));
                    check_field("mean_level", 32'(want.mean_level), 32'(m_tdata[21:4]));
                    check_field("min_level", 32'(want.lo_level), 32'(m_tdata[39:22]));
                    check_field("max_level", 32'(want.hi_level), 32'(m_tdata[57:40]));
                end
            end
            if (s_tvalid && s_tready) take_sample(s_tdata[SAMPLE_W-1:0]);
        end
        verdicts_due <= pending_reports.size();
        error_count  <= errs;
    end

endmodule

### sim/ppg_contact_quality_check_tb.sv
module ppg_contact_quality_check_tb;
    import ppgcq_pkg::*;

    localparam int WINDOW     = WINDOW_LEN_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    typedef enum int {
        SHAPE_FLAT,
        SHAPE_JITTER,
        SHAPE_SPIKE,
        SHAPE_ALTERNATE,
        SHAPE_NOISE
    } shape_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int verdicts_due;
    int error_count;
    int samples_sent = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;

    ppg_contact_quality_check #(.WINDOW_LEN(WINDOW)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ppgcq_verdict_monitor #(.WINDOW_LEN(WINDOW)) monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .verdicts_due (verdicts_due),
        .error_count  (error_count)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int pause_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic logic [SAMPLE_W-1:0] lift(input logic [SAMPLE_W-1:0] a,
                                                 input int unsigned d);
        logic [31:0] t;
        t = 32'(a) + d;
        return (t > 32'(FULL_SCALE)) ? FULL_SCALE : t[SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                     : $urandom_range(7, 59);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] x);
        int g;
        g = pause_len(tx_calm);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic send_window(input shape_t shape, input logic [SAMPLE_W-1:0] level,
                               input logic [SAMPLE_W-1:0] swing);
        logic [SAMPLE_W-1:0] x;
        int                  spike_at;
        spike_at = $urandom_range(0, WINDOW - 1);
        for (int i = 0; i < WINDOW; i++) begin
            case (shape)
                SHAPE_FLAT:      x = level;
                SHAPE_JITTER:    x = lift(level, $urandom_range(0, swing));
                SHAPE_SPIKE:     x = (i == spike_at) ? lift(level, swing) : level;
                SHAPE_ALTERNATE: x = i[0] ? lift(level, swing) : level;
                default:         x = SAMPLE_W'($urandom);
            endcase
            push_sample(x);
        end
    endtask

    // hold the sender until every request has been answered and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [APB_DATA_W-1:0] base,
                               input logic [APB_DATA_W-1:0] mult,
                               input logic [APB_DATA_W-1:0] stab,
                               input logic [APB_DATA_W-1:0] rmin,
                               input logic [APB_DATA_W-1:0] rmax);
        settle();
        apb_write(REG_BASELINE, base);
        apb_write(REG_MULT, mult);
        apb_write(REG_STAB, stab);
        apb_write(REG_RMIN, rmin);
        apb_write(REG_RMAX, rmax);
    endtask

    task automatic random_window();
        logic [SAMPLE_W-1:0] level;
        int                  r;
        level = SAMPLE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40000)
                                                      : $urandom_range(20000, 250000));
        r = $urandom_range(0, 99);
        if (r < 45)
            send_window(SHAPE_JITTER, level, level >> $urandom_range(2, 10));
        else if (r < 60)
            send_window(SHAPE_SPIKE, level, level >> $urandom_range(1, 5));
        else if (r < 70)
            send_window(SHAPE_FLAT, level, '0);
        else if (r < 80)
            send_window(SHAPE_ALTERNATE, level, SAMPLE_W'($urandom));
        else
            send_window(SHAPE_NOISE, '0, '0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_window(SHAPE_FLAT, FULL_SCALE, '0);
        send_window(SHAPE_FLAT, '0, '0);
        send_window(SHAPE_ALTERNATE, '0, FULL_SCALE);
        send_window(SHAPE_JITTER, 18'd100000, 18'd1000);
        send_window(SHAPE_SPIKE, 18'd100000, 18'd30000);

        // zero sum passes the level test only with a zero multiplier
        load_config(1, 0, 32'(STAB_RST), 32'(RMIN_RST), 32'(RMAX_RST));
        send_window(SHAPE_FLAT, '0, '0);
        load_config(1, 0, 32'(STAB_RST), 0, 32'(RMAX_RST));
        send_window(SHAPE_FLAT, '0, '0);

        load_config(0, 1023, 0, 0, 0);
        send_window(SHAPE_JITTER, 18'd1000, 18'd10);
        send_window(SHAPE_FLAT, 18'd5000, '0);
        load_config(262143, 1023, 65535, 65535, 65535);
        send_window(SHAPE_FLAT, FULL_SCALE, '0);
        send_window(SHAPE_NOISE, '0, '0);

        while (samples_sent < 900 - 4 * WINDOW) begin
            if ($urandom_range(0, 1))
                load_config($urandom_range(1, 30000), $urandom_range(150, 400),
                            $urandom_range(2000, 30000), $urandom_range(0, 2000),
                            $urandom_range(3000, 40000));
            else
                load_config($urandom, $urandom, $urandom, $urandom, $urandom);
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 7)) random_window();
        end

        tx_calm <= 1'b0;
        rx_calm <= 1'b0;
        settle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/ppgcq_pkg.sv
hdl/ppgcq_div.sv
hdl/ppgcq_dp.sv
hdl/ppgcq_ctrl.sv
hdl/ppg_contact_quality_check.sv
sim/ppgcq_verdict_monitor.sv
sim/ppg_contact_quality_check_tb.sv
